### src/dedup_pending_queue_top_macros.svh
// Assertion macros for the deduplicating pending queue.
// Included by dpq_back, which checks its own control logic; no other dependencies.
`ifndef DEDUP_PENDING_QUEUE_TOP_MACROS_SVH
`define DEDUP_PENDING_QUEUE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define DPQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dpq check failed");
// Next-cycle implication, disabled during reset.
`define DPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dpq check failed");
`else
`define DPQ_ASSERT_IMPL(label, ante, cons)
`define DPQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### src/dpq_pkg.sv
// Shared types and constants of the deduplicating pending queue.
// No dependencies; imported by every module of the block.
package dpq_pkg;

    localparam int DEPTH_DEF    = 32;
    localparam int KEY_BITS_DEF = 16;
    // Most beats that one drain emits.
    localparam int MAX_OUT      = 32;

    typedef enum logic [1:0] {
        OP_ENQ_UNIQUE = 2'd0,
        OP_ENQ_ALWAYS = 2'd1,
        OP_REMOVE     = 2'd2,
        OP_DRAIN      = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CMD_REPORT,
        CMD_UNIQUE,
        CMD_APPEND,
        CMD_REMOVE,
        CMD_DRAIN
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REMOVE,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic [1:0]  op;
        logic        queue_sel;
        logic [15:0] key;
        logic        monitor_enable;
    } t_in_item;

    typedef struct packed {
        logic [15:0] key_out;
        logic        item_valid;
        logic        found;
        logic        overflow;
        logic        queue_empty;
        logic        last;
    } t_out_item;

    // Classified command handed from the front to the back.
    typedef struct packed {
        t_kind       kind;
        logic        queue_sel;
        logic [15:0] key;
    } t_cmd;

endpackage

### src/dpq_front.sv
// Front end: accepts command beats, classifies them and holds them in a two-entry queue.
// Depends on dpq_pkg.
module dpq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  dpq_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    output dpq_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_pop
);
    import dpq_pkg::*;

    t_cmd       r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;

    // Classify the incoming beat; a disabled unique enqueue only reports.
    always_comb begin
        w_cmd.queue_sel = i_item.queue_sel;
        w_cmd.key       = i_item.key;
        unique case (t_op'(i_item.op))
            OP_ENQ_UNIQUE: w_cmd.kind = i_item.monitor_enable ? CMD_UNIQUE : CMD_REPORT;
            OP_ENQ_ALWAYS: w_cmd.kind = CMD_APPEND;
            OP_REMOVE:     w_cmd.kind = CMD_REMOVE;
            default:       w_cmd.kind = CMD_DRAIN;
        endcase
    end

    assign busy        = (r_cnt == 2'd2);
    assign w_push      = start && !busy;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_ent[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ent[r_wp] <= w_cmd;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_cmd_pop};
        end
    end
endmodule

### src/dpq_back.sv
// Back end: entry pool, the two linked lists, key match and the remove and drain walks.
// Depends on dpq_pkg and the assertion macro header.
`include "dedup_pending_queue_top_macros.svh"
module dpq_back #(
    parameter int DEPTH    = dpq_pkg::DEPTH_DEF,
    parameter int KEY_BITS = dpq_pkg::KEY_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  dpq_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_strobe,
    output dpq_pkg::t_out_item o_result
);
    import dpq_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Pool and list state.
    logic [DEPTH-1:0]    r_used, n_used;
    logic [DEPTH-1:0]    r_qid, n_qid;
    logic [KEY_BITS-1:0] r_key [DEPTH];
    logic [IW-1:0]       r_next [DEPTH];
    logic [IW-1:0]       n_next [DEPTH];
    logic [IW-1:0]       r_head [2];
    logic [IW-1:0]       n_head [2];
    logic [IW-1:0]       r_tail [2];
    logic [IW-1:0]       n_tail [2];
    logic [CW-1:0]       r_count [2];
    logic [CW-1:0]       n_count [2];

    // Walk state.
    t_state              r_state, n_state;
    logic [IW-1:0]       r_cur, n_cur;
    logic [IW-1:0]       r_prev, n_prev;
    logic                r_prev_ok, n_prev_ok;
    logic [CW-1:0]       r_left, n_left;
    logic                r_found, n_found;
    logic                r_wq, n_wq;
    logic [KEY_BITS-1:0] r_wkey, n_wkey;
    logic                r_empty_after, n_empty_after;

    // Result register.
    t_out_item           r_res, n_res;
    logic                r_strobe, n_strobe;

    // Key write port.
    logic                w_kwr;
    logic [IW-1:0]       w_kidx;

    logic                w_q;
    logic [KEY_BITS-1:0] w_key;
    logic [DEPTH-1:0]    w_hit;
    logic                w_free_any;
    logic [IW-1:0]       w_free;
    logic [CW-1:0]       w_m;
    logic [IW-1:0]       w_nxt;
    logic [15:0]         w_kout;

    assign w_q = i_cmd.queue_sel;

    // Fit the 16-bit key field to the stored key width.
    always_comb begin
        w_key = '0;
        for (int b = 0; b < KEY_BITS; b++) begin
            if (b < 16) begin
                w_key[b] = i_cmd.key[b];
            end
        end
    end

    // Parallel match over the pool and lowest free entry.
    always_comb begin
        w_free_any = 1'b0;
        w_free     = '0;
        for (int e = 0; e < DEPTH; e++) begin
            w_hit[e] = r_used[e] && (r_qid[e] == w_q) && (r_key[e] == w_key);
        end
        for (int e = DEPTH - 1; e >= 0; e--) begin
            if (!r_used[e]) begin
                w_free_any = 1'b1;
                w_free     = IW'(e);
            end
        end
    end

    // Number of beats of a drain.
    assign w_m = (int'(r_count[w_q]) > MAX_OUT) ? CW'(MAX_OUT) : r_count[w_q];

    assign w_nxt = r_next[r_cur];

    // Drained key widened or cut to the 16-bit output field.
    always_comb begin
        w_kout = '0;
        for (int b = 0; b < 16; b++) begin
            if (b < KEY_BITS) begin
                w_kout[b] = r_key[r_cur][b];
            end
        end
    end

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && (r_count[w_q] != '0)) begin
                    if (i_cmd.kind == CMD_REMOVE) begin
                        n_state = S_REMOVE;
                    end else if (i_cmd.kind == CMD_DRAIN) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_REMOVE, S_DRAIN: begin
                if (r_left == CW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and result of each step.
    always_comb begin
        n_used        = r_used;
        n_qid         = r_qid;
        n_next        = r_next;
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_cur         = r_cur;
        n_prev        = r_prev;
        n_prev_ok     = r_prev_ok;
        n_left        = r_left;
        n_found       = r_found;
        n_wq          = r_wq;
        n_wkey        = r_wkey;
        n_empty_after = r_empty_after;
        n_res         = '0;
        n_strobe      = 1'b0;
        w_kwr         = 1'b0;
        w_kidx        = w_free;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        CMD_UNIQUE, CMD_APPEND: begin
                            n_strobe = 1'b1;
                            n_res.last = 1'b1;
                            n_res.queue_empty = (r_count[w_q] == '0);
                            if ((i_cmd.kind == CMD_UNIQUE) && (|w_hit)) begin
                                n_res.found = 1'b1;
                            end else if (!w_free_any) begin
                                n_res.overflow = 1'b1;
                            end else begin
                                // Append at the tail of the selected list.
                                w_kwr = 1'b1;
                                n_used[w_free] = 1'b1;
                                n_qid[w_free] = w_q;
                                n_next[w_free] = '0;
                                if (r_count[w_q] == '0) begin
                                    n_head[w_q] = w_free;
                                end else begin
                                    n_next[r_tail[w_q]] = w_free;
                                end
                                n_tail[w_q] = w_free;
                                n_count[w_q] = r_count[w_q] + CW'(1);
                                n_res.queue_empty = 1'b0;
                            end
                        end
                        CMD_REMOVE: begin
                            n_cur     = r_head[w_q];
                            n_prev_ok = 1'b0;
                            n_left    = r_count[w_q];
                            n_found   = 1'b0;
                            n_wq      = w_q;
                            n_wkey    = w_key;
                            if (r_count[w_q] == '0) begin
                                n_strobe = 1'b1;
                                n_res.last = 1'b1;
                                n_res.queue_empty = 1'b1;
                            end
                        end
                        CMD_DRAIN: begin
                            n_cur  = r_head[w_q];
                            n_left = w_m;
                            n_wq   = w_q;
                            n_empty_after = (r_count[w_q] == w_m);
                            if (r_count[w_q] == '0) begin
                                n_strobe = 1'b1;
                                n_res.last = 1'b1;
                                n_res.queue_empty = 1'b1;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_res.last = 1'b1;
                            n_res.queue_empty = (r_count[w_q] == '0);
                        end
                    endcase
                end
            end
            S_REMOVE: begin
                // Unlink the current entry when it matches, else it becomes the predecessor.
                if (r_key[r_cur] == r_wkey) begin
                    n_used[r_cur] = 1'b0;
                    n_count[r_wq] = r_count[r_wq] - CW'(1);
                    if (!r_prev_ok) begin
                        n_head[r_wq] = w_nxt;
                    end else begin
                        n_next[r_prev] = w_nxt;
                    end
                    if (r_cur == r_tail[r_wq]) begin
                        n_tail[r_wq] = r_prev;
                    end
                    n_found = 1'b1;
                end else begin
                    n_prev    = r_cur;
                    n_prev_ok = 1'b1;
                end
                n_cur  = w_nxt;
                n_left = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_strobe = 1'b1;
                    n_res.last = 1'b1;
                    n_res.found = n_found;
                    n_res.queue_empty = (n_count[r_wq] == '0);
                end
            end
            S_DRAIN: begin
                // Emit the head entry and free it.
                n_strobe = 1'b1;
                n_res.key_out = w_kout;
                n_res.item_valid = 1'b1;
                n_res.queue_empty = r_empty_after;
                n_res.last = (r_left == CW'(1));
                n_used[r_cur] = 1'b0;
                n_head[r_wq] = w_nxt;
                n_count[r_wq] = r_count[r_wq] - CW'(1);
                n_cur  = w_nxt;
                n_left = r_left - CW'(1);
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    // Key store.
    always_ff @(posedge i_clk) begin
        if (w_kwr) begin
            r_key[w_kidx] <= w_key;
        end
    end

    // Links, walk payload and result payload.
    always_ff @(posedge i_clk) begin
        r_next        <= n_next;
        r_qid         <= n_qid;
        r_cur         <= n_cur;
        r_prev        <= n_prev;
        r_prev_ok     <= n_prev_ok;
        r_left        <= n_left;
        r_found       <= n_found;
        r_wq          <= n_wq;
        r_wkey        <= n_wkey;
        r_empty_after <= n_empty_after;
        r_res         <= n_res;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_head   <= '{default: '0};
            r_tail   <= '{default: '0};
            r_count  <= '{default: '0};
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

    // The fill counts always agree with the used entries.
    `DPQ_ASSERT_IMPL(a_count_used, 1'b1,
        $countones(r_used) == (int'(r_count[0]) + int'(r_count[1])))
    // A walk never runs with nothing left to visit.
    `DPQ_ASSERT_IMPL(a_walk_left, r_state != S_IDLE, r_left != '0)
    // The final step of a walk delivers the closing beat next cycle.
    `DPQ_ASSERT_NEXT(a_walk_end, (r_state != S_IDLE) && (r_left == CW'(1)),
        o_strobe && o_result.last)
    // Only drain beats carry a key.
    `DPQ_ASSERT_IMPL(a_key_valid, o_strobe && !o_result.item_valid,
        (o_result.key_out == '0) && o_result.last)
endmodule

### src/dedup_pending_queue_top.sv
// Top level of the deduplicating pending queue: front command queue and back executor.
// Depends on dpq_pkg, dpq_front and dpq_back.
//
// Usage: present a command beat on i_item with start high; it is taken at an edge where
// busy is low. busy rises only while the two-entry command queue is full.
// Results leave on o_result for exactly one cycle with o_strobe high; they cannot be held off.
// Enqueue, plain enqueue and a disabled unique enqueue give one result each, registered in the
// front command queue and then the result register; the back end retires one such command per
// cycle while no remove or drain walk runs. Remove by key walks the selected list one entry per
// cycle, unlinking every match, and reports whether any was found. Drain emits one beat per
// cycle, oldest first, up to 32, last marking the final one; an empty queue gives a single
// beat with item_valid low. The list walk through the link store sets these rates.
// Reset clears the used bits and both queues at once; no clearing pass is needed.
module dedup_pending_queue_top #(
    parameter int DEPTH    = dpq_pkg::DEPTH_DEF,
    parameter int KEY_BITS = dpq_pkg::KEY_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  dpq_pkg::t_in_item  i_item,
    output logic               o_strobe,
    output dpq_pkg::t_out_item o_result
);
    import dpq_pkg::*;

    logic w_cmd_valid;
    logic w_cmd_pop;
    t_cmd w_cmd;

    dpq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    dpq_back #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );
endmodule

### tb/dedup_pending_queue_top_tb.sv
// Self-checking testbench for the deduplicating pending queue.
// Depends on dpq_pkg and dedup_pending_queue_top; a scoreboard class predicts every result beat.
`timescale 1ns / 1ps

module dedup_pending_queue_top_tb;
    import dpq_pkg::*;

    localparam int POOL_SIZE   = 32;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_CMDS = 318;

    // Tracks the contents of both queues and the beats each command must produce.
    class result_scoreboard;
        bit [15:0] queued_keys[2][$];
        t_out_item awaited[$];
        int errors;
        int beats_checked;
        int overflows;
        int drained;

        function int pool_used();
            return queued_keys[0].size() + queued_keys[1].size();
        endfunction

        // Work out the beats caused by one accepted command.
        function void note_command(t_in_item cmd);
            t_out_item beat;
            int q;
            int n;
            bit hit;
            bit [15:0] kept[$];
            q = int'(cmd.queue_sel);
            beat = '0;
            beat.last = 1'b1;
            case (t_op'(cmd.op))
                OP_DRAIN: begin
                    n = queued_keys[q].size();
                    if (n > MAX_OUT) n = MAX_OUT;
                    if (n == 0) begin
                        beat.queue_empty = 1'b1;
                        awaited.push_back(beat);
                    end else begin
                        for (int i = 0; i < n; i++) begin
                            beat = '0;
                            beat.key_out = queued_keys[q].pop_front();
                            beat.item_valid = 1'b1;
                            beat.last = (i == n - 1);
                            awaited.push_back(beat);
                            drained++;
                        end
                        // The empty flag reflects the queue after the whole drain.
                        for (int i = awaited.size() - n; i < awaited.size(); i++)
                            awaited[i].queue_empty = (queued_keys[q].size() == 0);
                    end
                    return;
                end
                OP_ENQ_UNIQUE: begin
                    if (cmd.monitor_enable) begin
                        hit = 1'b0;
                        foreach (queued_keys[q][i])
                            if (queued_keys[q][i] == cmd.key) hit = 1'b1;
                        beat.found = hit;
                        if (!hit) begin
                            if (pool_used() >= POOL_SIZE) beat.overflow = 1'b1;
                            else queued_keys[q].push_back(cmd.key);
                        end
                    end
                end
                OP_ENQ_ALWAYS: begin
                    if (pool_used() >= POOL_SIZE) beat.overflow = 1'b1;
                    else queued_keys[q].push_back(cmd.key);
                end
                default: begin
                    hit = 1'b0;
                    foreach (queued_keys[q][i]) begin
                        if (queued_keys[q][i] == cmd.key) hit = 1'b1;
                        else kept.push_back(queued_keys[q][i]);
                    end
                    queued_keys[q] = kept;
                    beat.found = hit;
                end
            endcase
            if (beat.overflow) overflows++;
            beat.queue_empty = (queued_keys[q].size() == 0);
            awaited.push_back(beat);
        endfunction

        // Compare one result beat against the oldest awaited beat.
        function void check_result(t_out_item got);
            t_out_item want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result beat %p", $time, got);
                errors++;
                return;
            end
            want = awaited.pop_front();
            beats_checked++;
            if (got.key_out !== want.key_out)
                $display("%0t: key_out expected %h actual %h", $time, want.key_out, got.key_out);
            if (got.item_valid !== want.item_valid)
                $display("%0t: item_valid expected %b actual %b", $time, want.item_valid,
                         got.item_valid);
            if (got.found !== want.found)
                $display("%0t: found expected %b actual %b", $time, want.found, got.found);
            if (got.overflow !== want.overflow)
                $display("%0t: overflow expected %b actual %b", $time, want.overflow,
                         got.overflow);
            if (got.queue_empty !== want.queue_empty)
                $display("%0t: queue_empty expected %b actual %b", $time, want.queue_empty,
                         got.queue_empty);
            if (got.last !== want.last)
                $display("%0t: last expected %b actual %b", $time, want.last, got.last);
            if (got !== want) errors++;
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_strobe;
    t_out_item o_result;

    result_scoreboard sb;
    int  cycle_count;
    int  cmds_sent;
    bit  no_gaps;

    dedup_pending_queue_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // 20 ns clock.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Watch both sides of the block and end the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && start && !busy) sb.note_command(i_item);
        if (i_rst_n && o_strobe) sb.check_result(o_result);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d beats outstanding", $time, sb.awaited.size());
            $display("dedup_pending_queue_top_tb NOT OK");
            $finish;
        end
    end

    // Present one command beat after a random gap, none when no_gaps is set, and hold it until taken.
    task automatic send_cmd(input t_op op, input bit q, input bit [15:0] key, input bit en);
        int gap;
        gap = no_gaps ? 0 : int'($urandom_range(0, 13));
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= '{op: op, queue_sel: q, key: key, monitor_enable: en};
        do @(posedge i_clk); while (busy);
        cmds_sent++;
    endtask

    // Random command with keys mostly from a small set so duplicates and removals hit.
    task automatic send_random();
        int pick;
        t_op op;
        bit [15:0] key;
        pick = int'($urandom_range(0, 99));
        if (pick < 35) op = OP_ENQ_UNIQUE;
        else if (pick < 67) op = OP_ENQ_ALWAYS;
        else if (pick < 88) op = OP_REMOVE;
        else op = OP_DRAIN;
        key = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 7)) : 16'($urandom);
        send_cmd(op, 1'($urandom_range(0, 1)), key, $urandom_range(0, 9) != 0);
    endtask

    initial begin
        sb = new();
        cycle_count = 0;
        cmds_sent = 0;
        no_gaps = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty drains, key extremes, duplicates, disabled unique, removes.
        send_cmd(OP_DRAIN, 1'b0, 16'h0000, 1'b1);
        send_cmd(OP_DRAIN, 1'b1, 16'hFFFF, 1'b0);
        send_cmd(OP_ENQ_UNIQUE, 1'b0, 16'h0000, 1'b1);
        send_cmd(OP_ENQ_UNIQUE, 1'b0, 16'h0000, 1'b1);
        send_cmd(OP_ENQ_UNIQUE, 1'b0, 16'hFFFF, 1'b1);
        send_cmd(OP_ENQ_UNIQUE, 1'b1, 16'hFFFF, 1'b0);
        send_cmd(OP_ENQ_ALWAYS, 1'b1, 16'hFFFF, 1'b0);
        send_cmd(OP_ENQ_ALWAYS, 1'b1, 16'hFFFF, 1'b1);
        send_cmd(OP_ENQ_ALWAYS, 1'b1, 16'hA5A5, 1'b1);
        send_cmd(OP_ENQ_UNIQUE, 1'b1, 16'h5A5A, 1'b0);
        send_cmd(OP_REMOVE, 1'b1, 16'hFFFF, 1'b0);
        send_cmd(OP_REMOVE, 1'b1, 16'h1234, 1'b1);
        send_cmd(OP_REMOVE, 1'b0, 16'h0000, 1'b1);
        send_cmd(OP_DRAIN, 1'b0, 16'h0000, 1'b1);
        send_cmd(OP_DRAIN, 1'b1, 16'h0000, 1'b1);
        send_cmd(OP_REMOVE, 1'b0, 16'h0001, 1'b0);

        // Directed: fill the pool back to back, overflow both ways, then drain in full.
        no_gaps = 1'b1;
        for (int i = 0; i < POOL_SIZE; i++)
            send_cmd(OP_ENQ_ALWAYS, i[0], 16'(i * 16'h0801), 1'b1);
        send_cmd(OP_ENQ_ALWAYS, 1'b0, 16'hBEEF, 1'b1);
        send_cmd(OP_ENQ_UNIQUE, 1'b1, 16'hCAFE, 1'b1);
        send_cmd(OP_DRAIN, 1'b0, 16'h0000, 1'b0);
        send_cmd(OP_DRAIN, 1'b1, 16'h0000, 1'b0);
        no_gaps = 1'b0;

        // Random part, with stretches sent back to back.
        for (int i = 0; i < RANDOM_CMDS; i++) begin
            if (i % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            send_random();
        end
        start <= 1'b0;

        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("Sent %0d commands; checked %0d result beats, %0d drained keys, %0d overflows.",
                 cmds_sent, sb.beats_checked, sb.drained, sb.overflows);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("dedup_pending_queue_top_tb OK");
        end else begin
            $display("dedup_pending_queue_top_tb NOT OK");
        end
        $finish;
    end

endmodule
